// ===== rtl/cigar_split_position_finder_defines.svh =====
// ----------------------------------------------------------------------------
// CIGAR split position finder: assertion macros
// Concurrent assertion wrappers that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CIGAR_SPLIT_POSITION_FINDER_DEFINES_SVH
`define CIGAR_SPLIT_POSITION_FINDER_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define CSPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cspf: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cspf: next-cycle check failed");
`else
`define CSPF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/cspf_pkg.sv =====
// ----------------------------------------------------------------------------
// CIGAR split position finder package
// Character codes, strand codes, item and result types shared by the block.
// ----------------------------------------------------------------------------
package cspf_pkg;

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int START_W = 31;
	localparam int ACC_W   = 32;

	typedef enum logic [1:0] {
		STRAND_NONE = 2'd0,
		STRAND_FWD  = 2'd1,
		STRAND_REV  = 2'd2
	} strand_t;

	typedef struct packed {
		logic [7:0]         cigar_char;
		logic               first_char;
		logic               last_char;
		logic [START_W-1:0] start_one_based;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] split_pos;
		logic [1:0]              strand_code;
	} result_t;

	function automatic logic is_clip(input logic [7:0] c);
		return (c == CH_S) || (c == CH_H);
	endfunction

	function automatic logic adds_span(input logic [7:0] c);
		return (c == CH_D) || (c == CH_M) || (c == CH_EQ) || (c == CH_X);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ===== rtl/cigar_split_position_finder.sv =====
// ----------------------------------------------------------------------------
// CIGAR split position finder
// Reads a CIGAR string one character per transfer and reports the clip split.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle, back to back, while item_stall
// is low, and gives one result for each character marked last_char. result_valid
// is set by the clock edge that moves that character out of the input register,
// after which the result holds while result_stall is high. The record state
// update, shift-and-add arithmetic with saturating compares for each character,
// lies between the input register and the result register. A stalled result
// holds back only a following final character and the characters queued behind
// it; other characters keep flowing into the record state while the result waits.
`include "cigar_split_position_finder_defines.svh"

module cigar_split_position_finder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [7:0]                          cigar_char,
	input  logic                                first_char,
	input  logic                                last_char,
	input  logic [cspf_pkg::START_W-1:0]        start_one_based,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [cspf_pkg::ACC_W-1:0]   split_pos,
	output logic [1:0]                          strand_code
);
	import cspf_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t res_next;
	result_t res_q;

	// A final character may only leave the input register when the result
	// register is free or being emptied in this cycle.
	assign advance    = valid_s1 && !(item_s1.last_char && result_valid && result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.cigar_char      <= cigar_char;
			item_s1.first_char      <= first_char;
			item_s1.last_char       <= last_char;
			item_s1.start_one_based <= start_one_based;
		end
	end

	cspf_record u_record (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.item   (item_s1),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && item_s1.last_char) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_char) begin
			res_q <= res_next;
		end
	end

	assign split_pos   = res_q.split_pos;
	assign strand_code = res_q.strand_code;

	`CSPF_ASSERT_NEXT(a_last_gives_result, clk, arst_n,
		advance && item_s1.last_char, result_valid)
	`CSPF_ASSERT_NEXT(a_held_item_stays, clk, arst_n,
		valid_s1 && !advance, valid_s1 && $stable(item_s1))
	`CSPF_ASSERT_SAME(a_split_not_below_none, clk, arst_n,
		result_valid && split_pos[cspf_pkg::ACC_W-1], split_pos == '1)
	`CSPF_ASSERT_SAME(a_none_means_minus_one, clk, arst_n,
		result_valid && strand_code == STRAND_NONE, split_pos == '1)

endmodule

// ===== rtl/cspf_record.sv =====
// ----------------------------------------------------------------------------
// CIGAR split position finder: record state
// Holds the per-record accumulators and forms the result of a final character.
// ----------------------------------------------------------------------------
module cspf_record (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  cspf_pkg::item_t  item,
	output cspf_pkg::result_t res
);
	import cspf_pkg::*;

	logic [ACC_W-1:0] digit_q;
	logic [ACC_W-1:0] span_q;
	logic [ACC_W-1:0] start_q;
	logic             op_seen_q;
	logic             front_q;

	// State as seen by this character, after a new record has cleared it.
	logic [ACC_W-1:0] digit_eff;
	logic [ACC_W-1:0] span_eff;
	logic [ACC_W-1:0] start_eff;
	logic             op_seen_eff;
	logic             front_eff;

	logic             chr_digit;
	logic [ACC_W+3:0] digit_ext;
	logic [ACC_W+3:0] digit_mac;
	logic [ACC_W-1:0] digit_next;
	logic [ACC_W:0]   span_sum;
	logic [ACC_W-1:0] span_next;

	logic                    end_clip;
	logic                    front_any;
	logic signed [ACC_W+1:0] fwd_sum;
	logic signed [ACC_W-1:0] fwd_clamped;

	always_comb begin
		if (item.first_char) begin
			digit_eff   = '0;
			span_eff    = '0;
			op_seen_eff = 1'b0;
			front_eff   = 1'b0;
			start_eff   = {1'b0, item.start_one_based} - {{(ACC_W-1){1'b0}}, 1'b1};
		end else begin
			digit_eff   = digit_q;
			span_eff    = span_q;
			op_seen_eff = op_seen_q;
			front_eff   = front_q;
			start_eff   = start_q;
		end
	end

	assign chr_digit = is_digit(item.cigar_char);

	// Times ten as eight plus two, then the digit value from the low nibble.
	assign digit_ext  = {4'b0, digit_eff};
	assign digit_mac  = (digit_ext << 3) + (digit_ext << 1)
		+ {{ACC_W{1'b0}}, item.cigar_char[3:0]};
	assign digit_next = (|digit_mac[ACC_W+3:ACC_W]) ? '1 : digit_mac[ACC_W-1:0];

	assign span_sum  = {1'b0, span_eff} + {1'b0, digit_eff};
	assign span_next = span_sum[ACC_W] ? '1 : span_sum[ACC_W-1:0];

	// Result of a final character.
	assign end_clip  = !chr_digit && is_clip(item.cigar_char);
	assign front_any = op_seen_eff ? front_eff : end_clip;
	assign fwd_sum   = $signed({{2{start_eff[ACC_W-1]}}, start_eff})
		+ $signed({2'b00, span_eff}) - $signed({{(ACC_W+1){1'b0}}, 1'b1});

	always_comb begin
		if (fwd_sum > $signed({3'b000, {(ACC_W-1){1'b1}}})) begin
			fwd_clamped = {1'b0, {(ACC_W-1){1'b1}}};
		end else if (fwd_sum < -$signed({{(ACC_W+1){1'b0}}, 1'b1})) begin
			fwd_clamped = '1;
		end else begin
			fwd_clamped = fwd_sum[ACC_W-1:0];
		end
	end

	always_comb begin
		if (!front_any && end_clip) begin
			res.split_pos   = fwd_clamped;
			res.strand_code = STRAND_FWD;
		end else if (front_any && !end_clip) begin
			res.split_pos   = $signed(start_eff);
			res.strand_code = STRAND_REV;
		end else begin
			res.split_pos   = '1;
			res.strand_code = STRAND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q   <= '0;
			span_q    <= '0;
			start_q   <= '0;
			op_seen_q <= 1'b0;
			front_q   <= 1'b0;
		end else if (step_en) begin
			start_q <= start_eff;
			if (item.last_char) begin
				digit_q   <= '0;
				span_q    <= '0;
				op_seen_q <= 1'b0;
				front_q   <= 1'b0;
			end else if (chr_digit) begin
				digit_q   <= digit_next;
				span_q    <= span_eff;
				op_seen_q <= op_seen_eff;
				front_q   <= front_eff;
			end else begin
				digit_q   <= '0;
				span_q    <= adds_span(item.cigar_char) ? span_next : span_eff;
				op_seen_q <= 1'b1;
				front_q   <= op_seen_eff ? front_eff : is_clip(item.cigar_char);
			end
		end
	end

endmodule

// ===== bench/tb_cigar_split_position_finder.sv =====
// ----------------------------------------------------------------------------
// CIGAR split position finder testbench
// Sends CIGAR characters with random idle and stall cycles on both channels.
// A local model of the record state predicts each split point and strand.
// Every result is checked against the oldest prediction, in order.
// ----------------------------------------------------------------------------
module tb_cigar_split_position_finder;
	import cspf_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic signed [ACC_W-1:0] split_pos;
		strand_t                 strand;
	} split_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid;
	logic                       item_stall;
	logic [7:0]                 cigar_char;
	logic                       first_char;
	logic                       last_char;
	logic [START_W-1:0]         start_one_based;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [ACC_W-1:0]    split_pos;
	logic [1:0]                 strand_code;

	// Record state of the local model.
	logic [ACC_W-1:0] op_len = '0;
	logic [ACC_W-1:0] ref_span = '0;
	logic [ACC_W-1:0] start0 = '0;
	logic             any_op = 1'b0;
	logic             lead_clip = 1'b0;

	split_t expected_splits[$];
	int     send_idle_pct = 23;
	int     recv_stall_pct = 62;
	int     chars_sent = 0;
	int     idle_cycles = 0;
	bit     failed = 1'b0;

	cigar_split_position_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cigar_char(cigar_char),
		.first_char(first_char),
		.last_char(last_char),
		.start_one_based(start_one_based),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.split_pos(split_pos),
		.strand_code(strand_code)
	);

	always #4 clk = ~clk;

	// Advances the record state by one character and queues a split when it is final.
	task automatic track_cigar_char(input logic [7:0] c, input logic f, input logic l,
			input logic [START_W-1:0] s);
		logic            is_num;
		logic            end_clip;
		logic            lead;
		logic [ACC_W:0]  sum;
		longint          v;
		split_t          r;
		is_num = (c >= CH_ZERO) && (c <= CH_NINE);
		if (f) begin
			op_len = '0;
			ref_span = '0;
			any_op = 1'b0;
			lead_clip = 1'b0;
			start0 = {1'b0, s} - 32'd1;
		end
		if (!l) begin
			if (is_num) begin
				v = longint'(op_len) * 10 + longint'(c - CH_ZERO);
				op_len = (v > 64'hFFFF_FFFF) ? '1 : v[ACC_W-1:0];
			end else begin
				if (!any_op)
					lead_clip = c inside {CH_S, CH_H};
				any_op = 1'b1;
				if (c inside {CH_D, CH_M, CH_EQ, CH_X}) begin
					sum = {1'b0, ref_span} + {1'b0, op_len};
					ref_span = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
				end
				op_len = '0;
			end
		end else begin
			// A final digit closes the last operation as a non-clip.
			end_clip = !is_num && (c inside {CH_S, CH_H});
			lead = any_op ? lead_clip : end_clip;
			v = -1;
			r.strand = STRAND_NONE;
			if (!lead && end_clip) begin
				v = longint'($signed(start0)) + longint'(ref_span) - 1;
				r.strand = STRAND_FWD;
			end else if (lead && !end_clip) begin
				v = longint'($signed(start0));
				r.strand = STRAND_REV;
			end
			if (v < -1)
				v = -1;
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			r.split_pos = v[ACC_W-1:0];
			expected_splits = {expected_splits, r};
			op_len = '0;
			ref_span = '0;
			any_op = 1'b0;
			lead_clip = 1'b0;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic f, input logic l,
			input logic [START_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			cigar_char <= 8'($urandom);
			first_char <= 1'($urandom);
			last_char <= 1'($urandom);
			start_one_based <= START_W'($urandom);
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cigar_char <= c;
		first_char <= f;
		last_char <= l;
		start_one_based <= s;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		track_cigar_char(c, f, l, s);
		chars_sent++;
	endtask

	// The start field is only sampled with first_char, so later characters carry junk.
	task automatic send_text(input string txt, input logic [START_W-1:0] start,
			input bit new_record);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i], new_record && (i == 0), i == txt.len() - 1,
				(i == 0) ? start : START_W'($urandom));
	endtask

	task automatic test_clip_sides();
		send_text("2M3=S", 31'd1, 1'b1);
		send_text("5S7X", '1, 1'b1);
		// One character that is both first and last: a lone clip with a start of zero.
		send_char(CH_S, 1'b1, 1'b1, '0);
		send_text("4IS", '0, 1'b1);
	endtask

	task automatic test_saturation();
		send_text("9999999999DS", '1, 1'b1);
	endtask

	task automatic test_odd_endings();
		send_char(8'h34, 1'b1, 1'b0, '0);
		send_char(CH_H, 1'b0, 1'b0, START_W'($urandom));
		send_char(8'hFF, 1'b0, 1'b0, START_W'($urandom));
		send_char(8'h37, 1'b0, 1'b1, START_W'($urandom));
		send_char(8'h00, 1'b1, 1'b0, 31'd1);
		send_char(CH_S, 1'b0, 1'b1, START_W'($urandom));
	endtask

	task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n);
		string              txt;
		string              clips;
		string              body;
		int                 stop_at;
		int                 n_ops;
		int                 r;
		byte                op;
		logic [START_W-1:0] start;
		clips = "SH";
		body = "MMD=XINP";
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = chars_sent + n;
		while (chars_sent < stop_at) begin
			if ($urandom_range(4) == 0) begin
				for (int k = $urandom_range(1, 6); k > 0; k--)
					send_char(8'($urandom), $urandom_range(9) == 0,
						$urandom_range(6) == 0, START_W'($urandom));
			end else begin
				txt = "";
				n_ops = $urandom_range(1, 5);
				for (int k = 0; k < n_ops; k++) begin
					r = $urandom_range(99);
					if (r >= 8) begin
						if (r < 11)
							txt = $sformatf("%s%0d", txt, {$urandom, $urandom});
						else
							txt = $sformatf("%s%0d", txt, $urandom_range(999));
					end
					if ((k == 0 || k == n_ops - 1) && $urandom_range(1))
						op = clips[$urandom_range(1)];
					else
						op = body[$urandom_range(body.len() - 1)];
					txt = $sformatf("%s%c", txt, op);
				end
				if ($urandom_range(9) == 0)
					txt = $sformatf("%s%0d", txt, $urandom_range(9));
				r = $urandom_range(19);
				if (r == 0)
					start = '0;
				else if (r == 1)
					start = 31'd1;
				else if (r == 2)
					start = '1;
				else
					start = START_W'($urandom);
				send_text(txt, start, $urandom_range(9) != 0);
			end
		end
	endtask

	always @(posedge clk) begin
		split_t oldest;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_splits.size() == 0) begin
				$display("%0t: result with none pending: split_pos %0d strand %0d",
					$time, split_pos, strand_code);
				failed = 1'b1;
			end else begin
				oldest = expected_splits.pop_front();
				if (split_pos !== oldest.split_pos) begin
					$display("%0t: split_pos expected %0d actual %0d",
						$time, oldest.split_pos, split_pos);
					failed = 1'b1;
				end
				if (strand_code !== oldest.strand) begin
					$display("%0t: strand_code expected %0d actual %0d",
						$time, oldest.strand, strand_code);
					failed = 1'b1;
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Ends the run when no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		item_valid <= 1'b0;
		cigar_char <= '0;
		first_char <= 1'b0;
		last_char <= 1'b0;
		start_one_based <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clip_sides();
		test_saturation();
		test_odd_endings();
		test_random_stream(23, 62, 330);
		test_random_stream(62, 23, 330);
		test_random_stream(0, 0, 330);
		item_valid <= 1'b0;
		while (expected_splits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
